### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/spfl_pkg.sv
`default_nettype none

package spfl_pkg;

    localparam int SPFL_MAX_SLOTS_DEF = 1024;

    localparam int MODE_W = 2;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;

    localparam logic [CNT_W-1:0] SPB_RESET = 11'd64;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_SCAN0 = 2'd2,
        MODE_SCANN = 2'd3
    } mode_t;

endpackage

`default_nettype wire

### rtl/core/spfl_ram.sv
`default_nettype none

module spfl_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/slot_pool_free_list_allocator.sv
// Free and rejected requests finish in idle; each result is registered for output.
// Alloc reads, then pops the head; an empty list first grows the pool (S_GROW).
// Scans read one slot per cycle from the link/state memory.
// Items are handled one at a time; a new one is taken only in idle.
// Reset clears the free-list head, pool size, allocated count and out_valid;
// the memory is not cleared, growth writes each new slot before it is read.
`default_nettype none
`include "assert_macros.svh"

module slot_pool_free_list_allocator
    import spfl_pkg::*;
#(
    parameter int MAX_SLOTS = SPFL_MAX_SLOTS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CNT_W-1:0]  cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [IDX_W-1:0]  slot_index,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [IDX_W-1:0]       result_index,
    output logic                   found,
    output logic [CNT_W-1:0]       used_count,
    output logic [CNT_W-1:0]       free_count,
    output logic [CNT_W-1:0]       pool_size
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int AW = ((CW > CNT_W) ? CW : CNT_W) + 1;
    localparam int DW = CW + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_GROW  = 6'b000010,
        S_ARD   = 6'b000100,
        S_ALLOC = 6'b001000,
        S_SCAN  = 6'b010000,
        S_HOLD  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] spb_reg;
    logic [CW-1:0]    head_reg, head_next;
    logic [CW-1:0]    grown_reg, grown_next;
    logic [CW-1:0]    used_reg, used_next;
    logic [CW-1:0]    gptr_reg, gptr_next;
    logic [CW-1:0]    gtop_reg, gtop_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [IW-1:0]    chk_addr_reg, chk_addr_next;
    logic             inflight_reg, inflight_next;
    logic [IW-1:0]    hold_idx_reg;
    logic             hold_found_reg;

    logic [IDX_W-1:0] out_idx_reg;
    logic             out_found_reg;
    logic [CNT_W-1:0] out_used_reg;
    logic [CNT_W-1:0] out_free_reg;
    logic [CNT_W-1:0] out_pool_reg;
    logic             out_valid_reg;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [DW-1:0]    ram_wdata;
    logic             ram_re;
    logic [IW-1:0]    ram_raddr;
    logic [DW-1:0]    ram_rdata;

    logic             out_free;
    logic             fin;
    logic [IW-1:0]    fin_idx;
    logic             fin_found;
    logic [AW-1:0]    grow_sum;
    logic             grow_ok;
    logic             idx_in_range;
    logic [CW-1:0]    gptr_inc;

    spfl_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign out_free     = !out_valid_reg || !out_stall;
    assign grow_sum     = AW'(grown_reg) + AW'(spb_reg);
    assign grow_ok      = (spb_reg != '0) && (grow_sum <= AW'(MAX_SLOTS));
    assign idx_in_range = (AW'(slot_index) < AW'(grown_reg));
    assign gptr_inc     = gptr_reg + CW'(1);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        grown_next    = grown_reg;
        used_next     = used_reg;
        gptr_next     = gptr_reg;
        gtop_next     = gtop_reg;
        ptr_next      = ptr_reg;
        chk_addr_next = chk_addr_reg;
        inflight_next = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        fin           = 1'b0;
        fin_idx       = '0;
        fin_found     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (mode_t'(mode))
                        MODE_ALLOC:
                        begin
                            if (head_reg != grown_reg)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = IW'(head_reg);
                                state_next = S_ALLOC;
                            end
                            else if (grow_ok)
                            begin
                                gptr_next  = grown_reg;
                                gtop_next  = CW'(grow_sum);
                                state_next = S_GROW;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        MODE_FREE:
                        begin
                            fin = 1'b1;
                            if (idx_in_range)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = IW'(slot_index);
                                ram_wdata = {1'b0, head_reg};
                                head_next = CW'(slot_index);
                                if (used_reg != '0)
                                begin
                                    used_next = used_reg - CW'(1);
                                end
                                fin_idx   = IW'(slot_index);
                                fin_found = 1'b1;
                            end
                        end
                        MODE_SCAN0:
                        begin
                            ptr_next   = '0;
                            state_next = S_SCAN;
                        end
                        MODE_SCANN:
                        begin
                            if (idx_in_range)
                            begin
                                ptr_next   = CW'(AW'(slot_index) + AW'(1));
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_GROW:
            begin
                // link each new slot to the one after it
                ram_we    = 1'b1;
                ram_waddr = IW'(gptr_reg);
                ram_wdata = {1'b0, gptr_inc};
                gptr_next = gptr_inc;
                if (gptr_inc == gtop_reg)
                begin
                    grown_next = gtop_reg;
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = IW'(head_reg);
                state_next = S_ALLOC;
            end
            S_ALLOC:
            begin
                // pop the head and mark it taken, keeping its link
                ram_we    = 1'b1;
                ram_waddr = IW'(head_reg);
                ram_wdata = {1'b1, ram_rdata[CW-1:0]};
                head_next = ram_rdata[CW-1:0];
                if (used_reg < grown_reg)
                begin
                    used_next = used_reg + CW'(1);
                end
                fin       = 1'b1;
                fin_idx   = IW'(head_reg);
                fin_found = 1'b1;
            end
            S_SCAN:
            begin
                if (inflight_reg && ram_rdata[CW])
                begin
                    fin       = 1'b1;
                    fin_idx   = chk_addr_reg;
                    fin_found = 1'b1;
                end
                else if (ptr_reg < grown_reg)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = IW'(ptr_reg);
                    chk_addr_next = IW'(ptr_reg);
                    inflight_next = 1'b1;
                    ptr_next      = ptr_reg + CW'(1);
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = out_free ? S_IDLE : S_HOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            spb_reg       <= SPB_RESET;
            head_reg      <= '0;
            grown_reg     <= '0;
            used_reg      <= '0;
            inflight_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            grown_reg    <= grown_next;
            used_reg     <= used_next;
            inflight_reg <= inflight_next;
            if (cfg_we)
            begin
                spb_reg <= cfg_wdata;
            end
            if ((fin || (state_reg == S_HOLD)) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gptr_reg      <= gptr_next;
        gtop_reg      <= gtop_next;
        ptr_reg       <= ptr_next;
        chk_addr_reg  <= chk_addr_next;
        if (fin)
        begin
            hold_idx_reg   <= fin_idx;
            hold_found_reg <= fin_found;
        end
        if (fin && out_free)
        begin
            out_idx_reg   <= IDX_W'(fin_idx);
            out_found_reg <= fin_found;
            out_used_reg  <= CNT_W'(used_next);
            out_free_reg  <= CNT_W'(grown_next - used_next);
            out_pool_reg  <= CNT_W'(grown_next);
        end
        else if ((state_reg == S_HOLD) && out_free)
        begin
            out_idx_reg   <= IDX_W'(hold_idx_reg);
            out_found_reg <= hold_found_reg;
            out_used_reg  <= CNT_W'(used_reg);
            out_free_reg  <= CNT_W'(grown_reg - used_reg);
            out_pool_reg  <= CNT_W'(grown_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_index = out_idx_reg;
    assign found        = out_found_reg;
    assign used_count   = out_used_reg;
    assign free_count   = out_free_reg;
    assign pool_size    = out_pool_reg;

    `ASSERT_CLK(a_used_le_pool, used_reg <= grown_reg, "allocated count above pool size")
    `ASSERT_CLK(a_head_le_pool, head_reg <= grown_reg, "free-list head beyond pool")
    `ASSERT_NEVER(a_no_rw_clash, ram_we && ram_re && (ram_waddr == ram_raddr),
                  "read and write of one entry in one cycle")
    `ASSERT_CLK(a_pool_grows_once, (grown_reg != $past(grown_reg)) |-> ($past(state_reg) == S_GROW),
                "pool size changed outside growth")

endmodule

`default_nettype wire
